>>> hw/rtl/prp_pkg.sv
// ----------------------------------------------------------------------------
// prp_pkg: shared types, constants and helpers for the point projection unit
// Register indexes, fixed field widths, reset defaults and the final
// quotient merge and saturation functions.
// ----------------------------------------------------------------------------
package prp_pkg;

   // Control and status register port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 24;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_COS_YAW,
      CSR_SIN_YAW,
      CSR_COS_PITCH,
      CSR_SIN_PITCH,
      CSR_CAM_DIST,
      CSR_GAIN,
      CSR_WIDTH,
      CSR_HEIGHT
   } csr_index_type;

   // Fixed register and result widths
   localparam int TRIG_WIDTH     = 16;
   localparam int CAM_WIDTH      = 15;
   localparam int GAIN_WIDTH     = 24;
   localparam int SCREEN_BITS    = 13;
   localparam int CENTRE_WIDTH   = SCREEN_BITS - 1;
   localparam int OUT_WIDTH      = 16;
   localparam int RSP_DATA_WIDTH = 2 * OUT_WIDTH;
   localparam int RSP_USER_WIDTH = 2;

   // Fixed-point shifts
   localparam int TRIG_SHIFT = 14;
   localparam int X_SHIFT    = 6;
   localparam int YZ_SHIFT   = 20;
   localparam int DEN_SHIFT  = 8;
   localparam int FRAC_BITS  = 12;

   // Quotient bits kept by the divider; anything larger saturates anyway
   localparam int QUO_BITS    = 17;
   localparam int MERGE_WIDTH = QUO_BITS + 2;

   localparam int SAT_MAX = 32767;
   localparam int SAT_MIN = -32768;

   // Register reset values
   localparam logic signed [TRIG_WIDTH-1:0] COS_RESET   = 16'sd16384;
   localparam logic signed [TRIG_WIDTH-1:0] SIN_RESET   = 16'sd0;
   localparam logic [CAM_WIDTH-1:0]         CAM_RESET   = 15'd8192;
   localparam logic [GAIN_WIDTH-1:0]        GAIN_RESET  = 24'd4194304;
   localparam logic [SCREEN_BITS-1:0]       WIDTH_RESET = 13'd800;
   localparam logic [SCREEN_BITS-1:0]       HEIGHT_RESET = 13'd540;

   // Centre plus signed quotient, truncated toward zero; overflow pins to a limit
   function automatic logic signed [MERGE_WIDTH-1:0] merge_quotient(
      input logic [QUO_BITS-1:0]     quo,
      input logic [CENTRE_WIDTH-1:0] centre,
      input logic                    inexact,
      input logic                    neg,
      input logic                    ovf
   );
      logic signed [MERGE_WIDTH-1:0] res;
      priority if (ovf) begin
         res = neg ? MERGE_WIDTH'(SAT_MIN) : MERGE_WIDTH'(SAT_MAX);
      end else if (!neg) begin
         res = signed'(MERGE_WIDTH'(centre) + MERGE_WIDTH'(quo));
      end else if (quo >= QUO_BITS'(centre)) begin
         // result at or below zero: the floor step is undone by truncation
         res = signed'(MERGE_WIDTH'(centre) - MERGE_WIDTH'(quo));
      end else begin
         res = signed'(MERGE_WIDTH'(centre) - MERGE_WIDTH'(quo) -
                       MERGE_WIDTH'(inexact));
      end
      return res;
   endfunction

   // Clamp to the 16 bit result range
   function automatic logic signed [OUT_WIDTH-1:0] saturate_out(
      input logic signed [MERGE_WIDTH-1:0] val
   );
      logic signed [OUT_WIDTH-1:0] res;
      priority if (val > MERGE_WIDTH'(SAT_MAX)) begin
         res = OUT_WIDTH'(SAT_MAX);
      end else if (val < MERGE_WIDTH'(SAT_MIN)) begin
         res = OUT_WIDTH'(SAT_MIN);
      end else begin
         res = val[OUT_WIDTH-1:0];
      end
      return res;
   endfunction

endpackage

>>> hw/rtl/point_rotate_project_unit.sv
// ----------------------------------------------------------------------------
// point_rotate_project_unit: rotate a point about Y then X, project to screen
// Pipeline from request to result: six arithmetic stages, an overflow
// check, the 17-step restoring divider (one quotient bit a stage) and two output stages.
// Throughput: one request per clock unless stalled; a stalled stage only holds stages behind it.
// Reset: synchronous; clears all stage valid bits, reloads register defaults and
// holds both ready outputs low.
// ----------------------------------------------------------------------------
module point_rotate_project_unit #(
   parameter int  COORD_WIDTH    = 16,
   parameter int  NEAR_LIMIT     = 41,
   localparam int REQ_DATA_WIDTH = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // point_x, point_y, point_z (lowest first), zero padded to bytes
   input  logic [REQ_DATA_WIDTH-1:0]            req_tdata,
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // screen_x, screen_y (lowest first)
   output logic [prp_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   // in_front, on_screen (lowest first)
   output logic [prp_pkg::RSP_USER_WIDTH-1:0]   rsp_tuser,
   // register write port
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [prp_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [prp_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import prp_pkg::*;

   // Arithmetic widths
   localparam int PW   = COORD_WIDTH + TRIG_WIDTH;      // coord * trig
   localparam int TW   = PW + TRIG_WIDTH;               // coord * trig * trig
   localparam int SUMW = TW + 2;                        // sum of three terms
   localparam int XSW  = PW + 1;                        // rotated x before shift
   localparam int XW   = XSW - X_SHIFT;                 // rotated x, Q.8
   localparam int RW   = SUMW - YZ_SHIFT;               // rotated y and z, Q.8
   localparam int DW   = RW + 1;                        // signed denominator
   localparam int DMW  = RW;                            // positive denominator
   localparam int NW   = RW + GAIN_WIDTH - FRAC_BITS;   // dividend after >> 12
   localparam int CW   = DMW + QUO_BITS;                // divider compare width
   localparam int NEAR_SCALED = NEAR_LIMIT * (2 ** DEN_SHIFT);

   // Stage positions
   localparam int ST_OVF     = 6;
   localparam int ST_MERGE   = ST_OVF + QUO_BITS + 1;
   localparam int ST_OUT     = ST_MERGE + 1;
   localparam int NUM_STAGES = ST_OUT + 1;

   // ------------------------------------------------------------------------
   // Register file
   // ------------------------------------------------------------------------
   logic signed [TRIG_WIDTH-1:0] cos_yaw_ff, sin_yaw_ff, cos_pitch_ff, sin_pitch_ff;
   logic [CAM_WIDTH-1:0]         cam_dist_ff;
   logic [GAIN_WIDTH-1:0]        gain_ff;
   logic [SCREEN_BITS-1:0]       scr_width_ff, scr_height_ff;

   // Take writes only once out of reset
   assign csr_ready = ~reset;

   // Load defaults on reset, take a write whenever one is offered
   always_ff @(posedge clock) begin
      if (reset) begin
         cos_yaw_ff    <= COS_RESET;
         sin_yaw_ff    <= SIN_RESET;
         cos_pitch_ff  <= COS_RESET;
         sin_pitch_ff  <= SIN_RESET;
         cam_dist_ff   <= CAM_RESET;
         gain_ff       <= GAIN_RESET;
         scr_width_ff  <= WIDTH_RESET;
         scr_height_ff <= HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_COS_YAW:   cos_yaw_ff    <= csr_data[TRIG_WIDTH-1:0];
            CSR_SIN_YAW:   sin_yaw_ff    <= csr_data[TRIG_WIDTH-1:0];
            CSR_COS_PITCH: cos_pitch_ff  <= csr_data[TRIG_WIDTH-1:0];
            CSR_SIN_PITCH: sin_pitch_ff  <= csr_data[TRIG_WIDTH-1:0];
            CSR_CAM_DIST:  cam_dist_ff   <= csr_data[CAM_WIDTH-1:0];
            CSR_GAIN:      gain_ff       <= csr_data[GAIN_WIDTH-1:0];
            CSR_WIDTH:     scr_width_ff  <= csr_data[SCREEN_BITS-1:0];
            CSR_HEIGHT:    scr_height_ff <= csr_data[SCREEN_BITS-1:0];
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline flow control
   // ------------------------------------------------------------------------
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_up;
   logic [NUM_STAGES-1:0] stage_go;

   // A stage may load when the output is taken or a hole lies at or after it
   for (genvar gi = 0; gi < NUM_STAGES; gi++) begin : g_go
      assign stage_go[gi] = rsp_tready | ~(&vld_ff[NUM_STAGES-1:gi]);
   end

   assign vld_up     = {vld_ff[NUM_STAGES-2:0], req_tvalid};
   assign req_tready = stage_go[0] & ~reset;
   assign rsp_tvalid = vld_ff[NUM_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (stage_go[i]) begin
               vld_ff[i] <= vld_up[i];
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: coordinate times trig products
   // ------------------------------------------------------------------------
   logic signed [COORD_WIDTH-1:0] pt_x, pt_y, pt_z;
   logic signed [PW-1:0] m_xsp_s1_ff, m_ycp_s1_ff, m_zsp_s1_ff, m_xcp_s1_ff;
   logic signed [PW-1:0] m_ysp_s1_ff, m_zcp_s1_ff, m_xcy_s1_ff, m_zsy_s1_ff;

   assign pt_x = req_tdata[COORD_WIDTH-1:0];
   assign pt_y = req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
   assign pt_z = req_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];

   always_ff @(posedge clock) begin
      if (stage_go[0]) begin
         m_xsp_s1_ff <= pt_x * sin_pitch_ff;
         m_ycp_s1_ff <= pt_y * cos_pitch_ff;
         m_zsp_s1_ff <= pt_z * sin_pitch_ff;
         m_xcp_s1_ff <= pt_x * cos_pitch_ff;
         m_ysp_s1_ff <= pt_y * sin_pitch_ff;
         m_zcp_s1_ff <= pt_z * cos_pitch_ff;
         m_xcy_s1_ff <= pt_x * cos_yaw_ff;
         m_zsy_s1_ff <= pt_z * sin_yaw_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: second trig products, rotated x
   // ------------------------------------------------------------------------
   logic signed [TW-1:0]  t_a_s2_ff, t_b_s2_ff, t_c_s2_ff, t_d_s2_ff;
   logic signed [PW-1:0]  m_ycp_s2_ff, m_ysp_s2_ff;
   logic signed [XSW-1:0] xsum;
   logic signed [XW-1:0]  xr_s2_ff;

   assign xsum = m_xcy_s1_ff + m_zsy_s1_ff;

   always_ff @(posedge clock) begin
      if (stage_go[1]) begin
         t_a_s2_ff   <= m_xsp_s1_ff * sin_yaw_ff;
         t_b_s2_ff   <= m_zsp_s1_ff * cos_yaw_ff;
         t_c_s2_ff   <= m_xcp_s1_ff * sin_yaw_ff;
         t_d_s2_ff   <= m_zcp_s1_ff * cos_yaw_ff;
         m_ycp_s2_ff <= m_ycp_s1_ff;
         m_ysp_s2_ff <= m_ysp_s1_ff;
         // floor to Q.8
         xr_s2_ff    <= xsum[XSW-1:X_SHIFT];
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: rotated y and z
   // ------------------------------------------------------------------------
   logic signed [SUMW-1:0] ysum, zsum;
   logic signed [XW-1:0]   xr_s3_ff;
   logic signed [RW-1:0]   yr_s3_ff, zr_s3_ff;

   assign ysum = SUMW'(t_a_s2_ff) - SUMW'(t_b_s2_ff) + (SUMW'(m_ycp_s2_ff) <<< TRIG_SHIFT);
   assign zsum = SUMW'(t_d_s2_ff) - SUMW'(t_c_s2_ff) + (SUMW'(m_ysp_s2_ff) <<< TRIG_SHIFT);

   always_ff @(posedge clock) begin
      if (stage_go[2]) begin
         xr_s3_ff <= xr_s2_ff;
         yr_s3_ff <= ysum[SUMW-1:YZ_SHIFT];
         zr_s3_ff <= zsum[SUMW-1:YZ_SHIFT];
      end
   end

   // ------------------------------------------------------------------------
   // Stage 4: denominator and near-plane test
   // ------------------------------------------------------------------------
   logic signed [DW-1:0]  den_full;
   logic                  front_in;
   logic signed [XW-1:0]  xr_s4_ff;
   logic signed [RW-1:0]  yr_s4_ff;
   logic [DMW-1:0]        den_s4_ff;
   logic                  front_s4_ff;

   assign den_full = DW'(signed'({1'b0, cam_dist_ff, {DEN_SHIFT{1'b0}}})) - DW'(zr_s3_ff);
   assign front_in = den_full > DW'(NEAR_SCALED);

   always_ff @(posedge clock) begin
      if (stage_go[3]) begin
         xr_s4_ff    <= xr_s3_ff;
         yr_s4_ff    <= yr_s3_ff;
         den_s4_ff   <= den_full[DMW-1:0];
         front_s4_ff <= front_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 5: magnitudes and signs of the dividends
   // ------------------------------------------------------------------------
   logic [XW-1:0]  ax_s5_ff;
   logic [RW-1:0]  ay_s5_ff;
   logic           negx_s5_ff, negy_s5_ff, front_s5_ff;
   logic [DMW-1:0] den_s5_ff;

   always_ff @(posedge clock) begin
      if (stage_go[4]) begin
         ax_s5_ff    <= xr_s4_ff[XW-1] ? unsigned'(-xr_s4_ff) : unsigned'(xr_s4_ff);
         ay_s5_ff    <= yr_s4_ff[RW-1] ? unsigned'(-yr_s4_ff) : unsigned'(yr_s4_ff);
         negx_s5_ff  <= xr_s4_ff[XW-1];
         // the row subtracts y, so a positive y gives a negative dividend
         negy_s5_ff  <= ~yr_s4_ff[RW-1] & (|yr_s4_ff);
         den_s5_ff   <= den_s4_ff;
         front_s5_ff <= front_s4_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 6: dividend = magnitude * gain, drop the Q12 fraction
   // ------------------------------------------------------------------------
   logic [XW+GAIN_WIDTH-1:0] nx_full;
   logic [RW+GAIN_WIDTH-1:0] ny_full;
   logic [NW-1:0]            hix_s6_ff, hiy_s6_ff;
   logic                     lnzx_s6_ff, lnzy_s6_ff, negx_s6_ff, negy_s6_ff;
   logic                     front_s6_ff;
   logic [DMW-1:0]           den_s6_ff;

   assign nx_full = ax_s5_ff * gain_ff;
   assign ny_full = ay_s5_ff * gain_ff;

   always_ff @(posedge clock) begin
      if (stage_go[5]) begin
         hix_s6_ff   <= NW'(nx_full[XW+GAIN_WIDTH-1:FRAC_BITS]);
         hiy_s6_ff   <= ny_full[RW+GAIN_WIDTH-1:FRAC_BITS];
         lnzx_s6_ff  <= |nx_full[FRAC_BITS-1:0];
         lnzy_s6_ff  <= |ny_full[FRAC_BITS-1:0];
         negx_s6_ff  <= negx_s5_ff;
         negy_s6_ff  <= negy_s5_ff;
         den_s6_ff   <= den_s5_ff;
         front_s6_ff <= front_s5_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Divider: overflow check, then one restoring step per stage
   // ------------------------------------------------------------------------
   logic [NW-1:0]       rem_x_ff [QUO_BITS+1];
   logic [NW-1:0]       rem_y_ff [QUO_BITS+1];
   logic [QUO_BITS-1:0] quo_x_ff [QUO_BITS+1];
   logic [QUO_BITS-1:0] quo_y_ff [QUO_BITS+1];
   logic [DMW-1:0]      den_dv_ff [QUO_BITS+1];
   logic [QUO_BITS:0]   ovf_x_ff, ovf_y_ff, neg_x_ff, neg_y_ff;
   logic [QUO_BITS:0]   lnz_x_ff, lnz_y_ff, front_dv_ff;
   logic [CW-1:0]       den_top;

   // Quotients of 2^QUO_BITS or more saturate, so flag them up front
   assign den_top = {den_s6_ff, {QUO_BITS{1'b0}}};

   always_ff @(posedge clock) begin
      if (stage_go[ST_OVF]) begin
         rem_x_ff[0]    <= hix_s6_ff;
         rem_y_ff[0]    <= hiy_s6_ff;
         quo_x_ff[0]    <= '0;
         quo_y_ff[0]    <= '0;
         den_dv_ff[0]   <= den_s6_ff;
         ovf_x_ff[0]    <= CW'(hix_s6_ff) >= den_top;
         ovf_y_ff[0]    <= CW'(hiy_s6_ff) >= den_top;
         neg_x_ff[0]    <= negx_s6_ff;
         neg_y_ff[0]    <= negy_s6_ff;
         lnz_x_ff[0]    <= lnzx_s6_ff;
         lnz_y_ff[0]    <= lnzy_s6_ff;
         front_dv_ff[0] <= front_s6_ff;
      end
   end

   for (genvar gj = 0; gj < QUO_BITS; gj++) begin : g_div
      localparam int BIT_POS = QUO_BITS - 1 - gj;

      logic [CW-1:0]       dsh;
      logic                take_x, take_y;
      logic [NW-1:0]       rem_x_in, rem_y_in;
      logic [QUO_BITS-1:0] quo_x_in, quo_y_in;

      // Subtract the shifted divisor where it fits
      always_comb begin
         dsh      = CW'(den_dv_ff[gj]) << BIT_POS;
         take_x   = CW'(rem_x_ff[gj]) >= dsh;
         take_y   = CW'(rem_y_ff[gj]) >= dsh;
         rem_x_in = take_x ? NW'(CW'(rem_x_ff[gj]) - dsh) : rem_x_ff[gj];
         rem_y_in = take_y ? NW'(CW'(rem_y_ff[gj]) - dsh) : rem_y_ff[gj];
         quo_x_in = quo_x_ff[gj];
         quo_y_in = quo_y_ff[gj];
         quo_x_in[BIT_POS] = take_x;
         quo_y_in[BIT_POS] = take_y;
      end

      always_ff @(posedge clock) begin
         if (stage_go[ST_OVF+1+gj]) begin
            rem_x_ff[gj+1]    <= rem_x_in;
            rem_y_ff[gj+1]    <= rem_y_in;
            quo_x_ff[gj+1]    <= quo_x_in;
            quo_y_ff[gj+1]    <= quo_y_in;
            den_dv_ff[gj+1]   <= den_dv_ff[gj];
            ovf_x_ff[gj+1]    <= ovf_x_ff[gj];
            ovf_y_ff[gj+1]    <= ovf_y_ff[gj];
            neg_x_ff[gj+1]    <= neg_x_ff[gj];
            neg_y_ff[gj+1]    <= neg_y_ff[gj];
            lnz_x_ff[gj+1]    <= lnz_x_ff[gj];
            lnz_y_ff[gj+1]    <= lnz_y_ff[gj];
            front_dv_ff[gj+1] <= front_dv_ff[gj];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Merge: add the raster centre, truncate toward zero
   // ------------------------------------------------------------------------
   logic                          inexact_x, inexact_y;
   logic signed [MERGE_WIDTH-1:0] mx_in, my_in, mx_ff, my_ff;
   logic                          front_mg_ff;

   assign inexact_x = lnz_x_ff[QUO_BITS] | (|rem_x_ff[QUO_BITS]);
   assign inexact_y = lnz_y_ff[QUO_BITS] | (|rem_y_ff[QUO_BITS]);
   assign mx_in = merge_quotient(quo_x_ff[QUO_BITS], scr_width_ff[SCREEN_BITS-1:1],
                                 inexact_x, neg_x_ff[QUO_BITS], ovf_x_ff[QUO_BITS]);
   assign my_in = merge_quotient(quo_y_ff[QUO_BITS], scr_height_ff[SCREEN_BITS-1:1],
                                 inexact_y, neg_y_ff[QUO_BITS], ovf_y_ff[QUO_BITS]);

   always_ff @(posedge clock) begin
      if (stage_go[ST_MERGE]) begin
         mx_ff       <= mx_in;
         my_ff       <= my_in;
         front_mg_ff <= front_dv_ff[QUO_BITS];
      end
   end

   // ------------------------------------------------------------------------
   // Output register: saturate, zero points behind the camera, bounds test
   // ------------------------------------------------------------------------
   logic signed [OUT_WIDTH-1:0] sx_in, sy_in, sx_ff, sy_ff;
   logic                        on_screen_in, on_screen_ff, in_front_ff;

   assign sx_in = front_mg_ff ? saturate_out(mx_ff) : '0;
   assign sy_in = front_mg_ff ? saturate_out(my_ff) : '0;
   assign on_screen_in = front_mg_ff & ~sx_in[OUT_WIDTH-1] & ~sy_in[OUT_WIDTH-1] &
                         (unsigned'(sx_in) < OUT_WIDTH'(scr_width_ff)) &
                         (unsigned'(sy_in) < OUT_WIDTH'(scr_height_ff));

   always_ff @(posedge clock) begin
      if (stage_go[ST_OUT]) begin
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         in_front_ff  <= front_mg_ff;
         on_screen_ff <= on_screen_in;
      end
   end

   assign rsp_tdata = {sy_ff, sx_ff};
   assign rsp_tuser = {on_screen_ff, in_front_ff};

endmodule
